[src/kli_pkg.sv]
// Shared types and constants of the keyframe linear interpolator.
package kli_pkg;

  localparam int unsigned KLI_MAX_KEYS = 64;
  localparam int unsigned KEY_COUNT_W  = 7;
  localparam int unsigned SLOT_W       = 6;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned COMP_W       = 32;
  localparam int unsigned VALUE_W      = 3 * COMP_W;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned FRAC_W       = FRAC_BITS + 1;

  localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RESET = KEY_COUNT_W'(2);
  localparam logic [FRAC_W-1:0]      FRAC_ONE        = FRAC_W'(1) << FRAC_BITS;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic [SLOT_W-1:0]        key_slot;
    logic [TIME_W-1:0]        key_time;
    logic signed [COMP_W-1:0] value_x;
    logic signed [COMP_W-1:0] value_y;
    logic signed [COMP_W-1:0] value_z;
    logic [TIME_W-1:0]        query_time;
  } kli_in_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] out_x;
    logic signed [COMP_W-1:0] out_y;
    logic signed [COMP_W-1:0] out_z;
    logic [SLOT_W-1:0]        segment_start;
  } kli_out_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] q;
    logic [TIME_W-1:0] t0;
    logic [TIME_W-1:0] t1;
  } kli_div_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] frac;
  } kli_div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_BLEND = 5'b01000,
    ST_DONE  = 5'b10000
  } kli_state_e;

endpackage

[src/kli_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module kli_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/kli_div.sv]
// Iterative restoring divider that yields the clamped Q1.16 segment fraction.
module kli_div import kli_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  kli_div_req_t req_i,
  output kli_div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(FRAC_BITS);

  logic                 busy_q;
  logic                 done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [TIME_W-1:0]    rem_q;
  logic [TIME_W-1:0]    den_q;
  logic [FRAC_BITS-1:0] quot_q;
  logic                 zero_q;
  logic                 one_q;
  logic [FRAC_W-1:0]    frac_q;

  logic [TIME_W:0]      rem2;
  logic                 fits;
  logic [TIME_W-1:0]    rem_d;
  logic [FRAC_BITS-1:0] quot_d;
  logic                 last_step;

  // While the query time lies inside the segment the remainder stays below the
  // divisor, so one compare and subtract per step produces one quotient bit.
  assign rem2      = {rem_q, 1'b0};
  assign fits      = rem2 >= {1'b0, den_q};
  assign rem_d     = fits ? TIME_W'(rem2 - {1'b0, den_q}) : TIME_W'(rem2);
  assign quot_d    = {quot_q[FRAC_BITS-2:0], fits};
  assign last_step = busy_q && (cnt_q == CNT_W'(FRAC_BITS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= last_step;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.q - req_i.t0;
      den_q  <= req_i.t1 - req_i.t0;
      quot_q <= '0;
      zero_q <= (req_i.t1 <= req_i.t0) || (req_i.q <= req_i.t0);
      one_q  <= req_i.q >= req_i.t1;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
    if (last_step) begin
      priority if (zero_q) begin
        frac_q <= '0;
      end else if (one_q) begin
        frac_q <= FRAC_ONE;
      end else begin
        frac_q <= {1'b0, quot_d};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.frac = frac_q;

endmodule

[src/keyframe_linear_interpolator.sv]
// Top level of the keyframe linear interpolator: key tables, segment search and blend.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): a transfer with mode set
// to write stores one key (time and x, y, z) into the slot given and produces no
// result. A transfer with mode set to query starts a search for the segment that
// holds query_time and produces exactly one result.
// Output channel (out_valid_o / out_stall_i / out_data_o): the blended x, y, z
// and the index of the segment's start key.
// Configuration: cfg_we_i writes cfg_wdata_i into the key count register. The user
// must write it only while no query is in flight; the block does not enforce this.
// A query runs in steps: the time table is scanned one key per cycle from key 0 until the
// segment is found, then a radix-2 divider computes the fraction and hands it over (the two
// key values are read from the value table meanwhile) and one shared multiplier blends the
// three components. One query is in flight at a time; in_stall_o is high from the query
// transfer until its result sits in the output register.
// A finished result waits in the output register while out_stall_i is high; the
// block meanwhile accepts key writes and the next query, which holds in its
// last cycle until the register is free. Reset empties the output register and
// sets the key count to 2; the key tables hold no defined contents until written.
module keyframe_linear_interpolator import kli_pkg::*; #(
  parameter int unsigned MAX_KEYS = KLI_MAX_KEYS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  kli_in_t                in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output kli_out_t               out_data_o,
  input  logic                   cfg_we_i,
  input  logic [KEY_COUNT_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW   = $clog2(MAX_KEYS);
  localparam int unsigned CNTW = (AW + 1 > KEY_COUNT_W) ? AW + 1 : KEY_COUNT_W;
  localparam int unsigned PW   = COMP_W + 1 + FRAC_W + 1;

  kli_state_e state_q, state_d;

  logic [KEY_COUNT_W-1:0] key_count_q;
  logic                   out_valid_q;
  kli_out_t               out_data_q;

  logic [AW-1:0]      idx_q;
  logic [AW-1:0]      a_q;
  logic [TIME_W-1:0]  prev_q;
  logic [TIME_W-1:0]  q_q;
  logic [1:0]         vcnt_q;
  logic [1:0]         bcnt_q;
  logic [VALUE_W-1:0] s_q;
  logic [VALUE_W-1:0] e_q;
  logic [VALUE_W-1:0] res_q;
  logic signed [COMP_W-1:0] sp_q;
  logic signed [PW-1:0]     prod_q;
  logic [FRAC_W-1:0]  frac_q;

  logic               in_acc;
  logic               out_free;
  logic [CNTW-1:0]    count_ext;
  logic [CNTW-1:0]    keys_used;
  logic [AW-1:0]      last_idx;
  logic               slot_ok;
  logic               key_we;
  logic [AW-1:0]      t_raddr;
  logic [TIME_W-1:0]  t_rdata;
  logic [AW-1:0]      v_raddr;
  logic [VALUE_W-1:0] v_rdata;
  logic               hit;

  logic signed [COMP_W-1:0] cur_s;
  logic signed [COMP_W-1:0] cur_e;
  logic signed [COMP_W:0]   diff;
  logic signed [PW-1:0]     prod_d;
  logic [COMP_W-1:0]        sum;

  kli_div_req_t div_req;
  kli_div_rsp_t div_rsp;

  assign in_stall_o = state_q != ST_IDLE;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Keys in use, clamped to the range the tables support.
  assign count_ext = CNTW'(key_count_q);
  always_comb begin
    priority if (count_ext < CNTW'(2)) begin
      keys_used = CNTW'(2);
    end else if (count_ext > CNTW'(MAX_KEYS)) begin
      keys_used = CNTW'(MAX_KEYS);
    end else begin
      keys_used = count_ext;
    end
  end
  assign last_idx = AW'(keys_used - CNTW'(1));

  assign slot_ok = CNTW'(in_data_i.key_slot) < CNTW'(MAX_KEYS);
  assign key_we  = in_acc && (in_data_i.mode == MODE_WRITE) && slot_ok;

  kli_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_KEYS)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (AW'(in_data_i.key_slot)),
    .wdata_i (in_data_i.key_time),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  kli_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_KEYS)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (AW'(in_data_i.key_slot)),
    .wdata_i ({in_data_i.value_x, in_data_i.value_y, in_data_i.value_z}),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  // During the scan t_rdata holds the time of key idx_q; the segment is found
  // at the first later key past the query time, or at the last key.
  assign hit = (idx_q != '0) && ((q_q < t_rdata) || (idx_q == last_idx));

  kli_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Start value is read in the first divider cycle, end value in the second.
  assign v_raddr = (vcnt_q == 2'd0) ? a_q : a_q + AW'(1);

  always_comb begin
    state_d       = state_q;
    div_req.start = 1'b0;
    div_req.q     = q_q;
    div_req.t0    = prev_q;
    div_req.t1    = t_rdata;
    t_raddr       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_data_i.mode == MODE_QUERY)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        t_raddr = idx_q + AW'(1);
        if (hit) begin
          div_req.start = 1'b1;
          state_d       = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_BLEND;
        end
      end
      ST_BLEND: begin
        if (bcnt_q == 2'd3) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // One component per cycle goes through the multiplier; the sum of each component is
  // formed from the registered product while the next component is multiplied.
  assign cur_s  = s_q[VALUE_W-1 -: COMP_W];
  assign cur_e  = e_q[VALUE_W-1 -: COMP_W];
  assign diff   = {cur_e[COMP_W-1], cur_e} - {cur_s[COMP_W-1], cur_s};
  assign prod_d = PW'(diff) * PW'($signed({1'b0, frac_q}));
  assign sum    = COMP_W'(sp_q) + prod_q[FRAC_BITS +: COMP_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_count_q <= KEY_COUNT_RESET;
      out_valid_q <= 1'b0;
      vcnt_q      <= '0;
      bcnt_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        key_count_q <= cfg_wdata_i;
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_SCAN) begin
        vcnt_q <= '0;
      end else if ((state_q == ST_DIV) && (vcnt_q != 2'd3)) begin
        vcnt_q <= vcnt_q + 2'd1;
      end
      if (state_q == ST_DIV) begin
        bcnt_q <= '0;
      end else if (state_q == ST_BLEND) begin
        bcnt_q <= bcnt_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      q_q <= in_data_i.query_time;
    end
    if (state_q == ST_IDLE) begin
      idx_q <= '0;
    end else if (state_q == ST_SCAN) begin
      idx_q  <= idx_q + AW'(1);
      prev_q <= t_rdata;
      if (hit) begin
        a_q <= idx_q - AW'(1);
      end
    end
    if (state_q == ST_DIV) begin
      if (vcnt_q == 2'd1) begin
        s_q <= v_rdata;
      end
      if (vcnt_q == 2'd2) begin
        e_q <= v_rdata;
      end
      if (div_rsp.done) begin
        frac_q <= div_rsp.frac;
      end
    end
    if (state_q == ST_BLEND) begin
      s_q    <= {s_q[VALUE_W-COMP_W-1:0], COMP_W'(0)};
      e_q    <= {e_q[VALUE_W-COMP_W-1:0], COMP_W'(0)};
      sp_q   <= cur_s;
      prod_q <= prod_d;
      if (bcnt_q != 2'd0) begin
        res_q <= {res_q[VALUE_W-COMP_W-1:0], sum};
      end
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_data_q.out_x         <= res_q[VALUE_W-1 -: COMP_W];
      out_data_q.out_y         <= res_q[COMP_W +: COMP_W];
      out_data_q.out_z         <= res_q[COMP_W-1:0];
      out_data_q.segment_start <= SLOT_W'(a_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_segment_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (a_q < last_idx))
    else $error("segment start lies at or past the last key");

  a_div_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_frac_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (div_rsp.frac <= FRAC_ONE))
    else $error("fraction above one");

  a_done_after_blend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |->
      (($past(state_q) == ST_DONE) || ($past(state_q) == ST_BLEND)))
    else $error("result stage entered without a blend");

endmodule

[test/kli_checker.sv]
// Checker for the keyframe interpolator: follows both channels, predicts each sample and compares.
module kli_checker import kli_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  kli_in_t                in_data_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  kli_out_t               out_data_i,
  input  logic                   cfg_we_i,
  input  logic [KEY_COUNT_W-1:0] cfg_wdata_i,
  output int                     pending_o,
  output int                     mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [KEY_COUNT_W-1:0]   key_count = KEY_COUNT_RESET;
  logic [TIME_W-1:0]        key_times [KLI_MAX_KEYS];
  logic signed [COMP_W-1:0] key_x [KLI_MAX_KEYS];
  logic signed [COMP_W-1:0] key_y [KLI_MAX_KEYS];
  logic signed [COMP_W-1:0] key_z [KLI_MAX_KEYS];

  kli_out_t pending_samples [$];
  kli_out_t wanted;
  int       mismatch_count = 0;

  function automatic logic signed [COMP_W-1:0] blend_comp(input logic signed [COMP_W-1:0] s,
                                                          input logic signed [COMP_W-1:0] e,
                                                          input logic [FRAC_W-1:0] f);
    longint prod;
    prod = (longint'(e) - longint'(s)) * longint'(f);
    // The arithmetic shift rounds the step toward minus infinity.
    return COMP_W'(longint'(s) + (prod >>> FRAC_BITS));
  endfunction

  function automatic kli_out_t interpolate_at(input logic [TIME_W-1:0] q);
    int unsigned         n, a, b;
    logic [TIME_W-1:0]   t0, t1;
    logic [FRAC_W-1:0]   f;
    logic [2*TIME_W-1:0] num, den;
    kli_out_t            r;
    n = (int'(key_count) < 2) ? 2 :
        ((int'(key_count) > KLI_MAX_KEYS) ? KLI_MAX_KEYS : int'(key_count));
    // A time past the last key falls back to the last segment.
    a = n - 2;
    for (int i = 0; i + 1 < n; i++) begin
      if (q < key_times[i + 1]) begin
        a = i;
        break;
      end
    end
    b  = a + 1;
    t0 = key_times[a];
    t1 = key_times[b];
    if (t1 <= t0 || q <= t0) begin
      f = '0;
    end else if (q >= t1) begin
      f = FRAC_ONE;
    end else begin
      num = {{TIME_W{1'b0}}, q - t0};
      num = num << FRAC_BITS;
      den = {{TIME_W{1'b0}}, t1 - t0};
      f   = FRAC_W'(num / den);
    end
    r.out_x         = blend_comp(key_x[a], key_x[b], f);
    r.out_y         = blend_comp(key_y[a], key_y[b], f);
    r.out_z         = blend_comp(key_z[a], key_z[b], f);
    r.segment_start = SLOT_W'(a);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count = KEY_COUNT_RESET;
      pending_samples.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        key_count = cfg_wdata_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_samples.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("[%0t] result with nothing pending: x=%h y=%h z=%h seg=%0d", $time,
                     out_data_i.out_x, out_data_i.out_y, out_data_i.out_z,
                     out_data_i.segment_start);
          end
          mismatch_count++;
        end else begin
          wanted = pending_samples.pop_front();
          if (out_data_i.out_x !== wanted.out_x || out_data_i.out_y !== wanted.out_y ||
              out_data_i.out_z !== wanted.out_z ||
              out_data_i.segment_start !== wanted.segment_start) begin
            if (mismatch_count < 10) begin
              $display("[%0t] sample mismatch: expected x=%h y=%h z=%h seg=%0d", $time,
                       wanted.out_x, wanted.out_y, wanted.out_z, wanted.segment_start);
              $display("[%0t]                  actual   x=%h y=%h z=%h seg=%0d", $time,
                       out_data_i.out_x, out_data_i.out_y, out_data_i.out_z,
                       out_data_i.segment_start);
            end
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.mode == MODE_WRITE) begin
          key_times[in_data_i.key_slot] = in_data_i.key_time;
          key_x[in_data_i.key_slot]     = in_data_i.value_x;
          key_y[in_data_i.key_slot]     = in_data_i.value_y;
          key_z[in_data_i.key_slot]     = in_data_i.value_z;
        end else begin
          pending_samples.push_back(interpolate_at(in_data_i.query_time));
        end
      end
      pending_o <= pending_samples.size();
    end
    mismatches_o <= mismatch_count;
  end

endmodule

[test/tb.sv]
// Testbench top for the keyframe interpolator: reset, key tables, key-count settings and queries.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kli_pkg::*;

  localparam int unsigned LIMIT_CYCLES    = 1_000_000;
  localparam int unsigned SETTLE_CYCLES   = 100;
  localparam int unsigned MAX_WAIT        = 6;
  localparam int unsigned PHASES          = 10;
  localparam int unsigned ITEMS_PER_PHASE = 145;

  localparam logic signed [COMP_W-1:0] COMP_MIN = 32'sh8000_0000;
  localparam logic signed [COMP_W-1:0] COMP_MAX = 32'sh7FFF_FFFF;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  kli_in_t                in_data_i   = '0;
  logic                   out_stall_i = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [KEY_COUNT_W-1:0] cfg_wdata_i = '0;
  logic                   in_stall_o;
  logic                   out_valid_o;
  kli_out_t               out_data_o;
  int                     pending;
  int                     mismatches;

  bit                     send_quiet = 1'b0;
  bit                     recv_quiet = 1'b0;
  int unsigned            keys_now   = 2;
  int                     key_writes = 0;
  int                     queries    = 0;
  int                     settings   = 0;
  logic [TIME_W-1:0]      written_times [KLI_MAX_KEYS];
  logic [KEY_COUNT_W-1:0] phase_counts [PHASES] =
    '{7'd64, 7'd0, 7'd127, 7'd2, 7'd1, 7'd65, 7'd3, 7'd33, 7'd64, 7'd64};

  always #5 clk_i = ~clk_i;

  keyframe_linear_interpolator #(
    .MAX_KEYS(KLI_MAX_KEYS)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o,
    .cfg_we_i,
    .cfg_wdata_i
  );

  kli_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i   (in_stall_o),
    .in_data_i,
    .out_valid_i  (out_valid_o),
    .out_stall_i,
    .out_data_i   (out_data_o),
    .cfg_we_i,
    .cfg_wdata_i,
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  function automatic logic signed [COMP_W-1:0] random_comp();
    case ($urandom_range(0, 7))
      0: return COMP_MIN;
      1: return COMP_MAX;
      2: return '0;
      3: return COMP_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  function automatic kli_in_t random_item();
    kli_in_t item;
    item.mode       = 1'($urandom_range(0, 1));
    item.key_slot   = SLOT_W'($urandom);
    item.key_time   = $urandom;
    item.value_x    = $urandom;
    item.value_y    = $urandom;
    item.value_z    = $urandom;
    item.query_time = $urandom;
    return item;
  endfunction

  // Query times cluster on and around the stored key times.
  function automatic logic [TIME_W-1:0] pick_query_time();
    int unsigned       k;
    logic [TIME_W-1:0] t0, t1;
    k  = $urandom_range(0, keys_now - 1);
    t0 = written_times[k];
    t1 = (k + 1 < keys_now) ? written_times[k + 1] : t0;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom;
      3: return t0;
      4: return t0 - 1;
      5: return t0 + 1;
      default: return (t1 > t0) ? t0 + $urandom_range(0, t1 - t0) : t0 + $urandom_range(0, 3);
    endcase
  endfunction

  task automatic send_item(input kli_in_t item);
    int unsigned gap;
    gap = send_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    if (item.mode == MODE_WRITE) begin
      written_times[item.key_slot] = item.key_time;
      key_writes++;
    end else begin
      queries++;
    end
  endtask

  task automatic write_key(input int unsigned slot, input logic [TIME_W-1:0] stamp,
                           input logic signed [COMP_W-1:0] x, y, z);
    kli_in_t item;
    item          = random_item();
    item.mode     = MODE_WRITE;
    item.key_slot = SLOT_W'(slot);
    item.key_time = stamp;
    item.value_x  = x;
    item.value_y  = y;
    item.value_z  = z;
    send_item(item);
  endtask

  task automatic query_at(input logic [TIME_W-1:0] q);
    kli_in_t item;
    item            = random_item();
    item.mode       = MODE_QUERY;
    item.query_time = q;
    send_item(item);
  endtask

  task automatic drain(input int unsigned settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_key_count(input logic [KEY_COUNT_W-1:0] count);
    drain(SETTLE_CYCLES);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    keys_now = (int'(count) < 2) ? 2 :
               ((int'(count) > KLI_MAX_KEYS) ? KLI_MAX_KEYS : int'(count));
    settings++;
  endtask

  // Style 0 ascends from low times, style 1 ascends into the top of the range and
  // saturates there, style 2 scatters times so that many segments run backward.
  task automatic fill_table(input int unsigned style);
    logic [TIME_W-1:0] stamp, stride;
    logic [TIME_W:0]   next;
    stamp = (style == 1) ? 32'hFFF0_0000 + $urandom_range(0, 20'hF_FFFF)
                         : $urandom_range(0, 1 << 20);
    for (int s = 0; s < KLI_MAX_KEYS; s++) begin
      if (style == 2) begin
        stamp = $urandom;
      end
      write_key(s, stamp, random_comp(), random_comp(), random_comp());
      case ($urandom_range(0, 5))
        0:       stride = '0;
        1:       stride = $urandom_range(1, 16);
        2, 3:    stride = $urandom_range(1, 1 << 16);
        default: stride = $urandom_range(1, 1 << 24);
      endcase
      next  = {1'b0, stamp} + stride;
      stamp = next[TIME_W] ? '1 : next[TIME_W-1:0];
    end
  endtask

  initial begin : result_sink
    int unsigned hold;
    forever begin
      hold = recv_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      repeat (hold) begin
        out_stall_i <= 1'b1;
        @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned            slot, choice;
    logic [TIME_W-1:0]      lo, hi, stamp;
    logic [KEY_COUNT_W-1:0] count;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Two keys at the reset key count, full-range values in opposite directions.
    write_key(0, 100, COMP_MIN, COMP_MAX, 0);
    write_key(1, 1100, COMP_MAX, COMP_MIN, -3);
    query_at(0);
    query_at(100);
    query_at(101);
    query_at(600);
    query_at(1099);
    query_at(1100);
    query_at('1);
    // Zero-length segment.
    write_key(1, 100, 65536, -65536, 7);
    query_at(100);
    query_at(5000);
    // Segment whose end key lies earlier than its start key.
    write_key(1, 50, COMP_MIN, 1, -1);
    query_at(75);
    query_at(200);
    // Segment spanning the whole time range.
    write_key(0, 0, -1, 1, COMP_MIN);
    write_key(1, '1, 1, -1, COMP_MAX);
    query_at(32'h7FFF_FFFF);
    query_at(32'hFFFF_FFFE);
    query_at(1);

    for (int p = 0; p < PHASES; p++) begin
      count = (p < 8) ? phase_counts[p] : KEY_COUNT_W'($urandom_range(2, KLI_MAX_KEYS));
      set_key_count(count);
      if (p == 0) begin
        fill_table(0);
      end else if ($urandom_range(0, 2) == 0) begin
        fill_table($urandom_range(0, 2));
      end
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        choice = $urandom_range(0, 99);
        if (choice < 80) begin
          query_at(pick_query_time());
        end else if (choice < 95) begin
          // Rewrite one key in use, mostly keeping it between its neighbors.
          slot = $urandom_range(0, keys_now - 1);
          lo   = (slot > 0) ? written_times[slot - 1] : '0;
          hi   = (slot + 1 < keys_now) ? written_times[slot + 1] : '1;
          stamp = (hi >= lo && $urandom_range(0, 3) != 0) ? lo + $urandom_range(0, hi - lo)
                                                          : $urandom;
          write_key(slot, stamp, random_comp(), random_comp(), random_comp());
        end else begin
          send_item(random_item());
        end
        if ($urandom_range(0, 59) == 0) begin
          drain(0);
        end
      end
    end

    drain(SETTLE_CYCLES);
    $display("Run covered %0d key writes and %0d queries over %0d key-count settings,",
             key_writes, queries, settings);
    $display("with counts below, at and above the legal range and flat, backward and open segments.");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
